/* rtl/ssimh_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, widths and payload types for the skyline sweep block.
// No dependencies.
package ssimh_pkg;

	localparam int MAX_BLD = 1024;
	localparam int IDX_W   = $clog2(MAX_BLD);
	localparam int CNT_W   = $clog2(MAX_BLD + 1);
	localparam int X_W     = 31;
	localparam int H_W     = 31;
	localparam int ID_W    = 10;

	typedef logic [X_W-1:0]   x_t;
	typedef logic [H_W-1:0]   h_t;
	typedef logic [ID_W-1:0]  id_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		x_t   x_position;
		h_t   building_height;
		id_t  building_id;
		logic is_entering;
	} evt_t;

	typedef struct packed {
		x_t key_x;
		h_t key_height;
	} key_t;

	// broadcast to every cell: insert val, or drop one entry of height val
	typedef struct packed {
		logic ins;
		logic del;
		h_t   val;
	} cell_op_t;

endpackage

/* rtl/ssimh_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels for edge events and skyline key points.
// Depends on ssimh_pkg.
interface ssimh_evt_if import ssimh_pkg::*; ();
	logic valid;
	logic ready;
	evt_t beat;
	modport source (output valid, output beat, input ready);
	modport sink (input valid, input beat, output ready);
endinterface

interface ssimh_key_if import ssimh_pkg::*; ();
	logic valid;
	logic ready;
	key_t beat;
	modport source (output valid, output beat, input ready);
	modport sink (input valid, input beat, output ready);
endinterface

/* rtl/ssimh_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted height row: holds one height, shifts with its neighbors.
// Depends on ssimh_pkg.
module ssimh_cell import ssimh_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  logic     beyond,
	input  logic     left_flag,
	input  h_t       left_key,
	input  h_t       right_key,
	output logic     flag,
	output h_t       key
);

	h_t key_q;

	// insert: new value belongs at or before this cell; delete: this cell at or past the hole
	assign flag = beyond | (op.ins ? (op.val > key_q) : (op.val >= key_q));
	assign key  = key_q;

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (left_flag) begin
				key_q <= left_key;
			end else if (flag) begin
				key_q <= op.val;
			end
		end else if (op.del && flag) begin
			key_q <= right_key;
		end
	end

endmodule

/* rtl/ssimh_row.sv */
`timescale 1ns / 1ps
// Row of cells keeping active heights sorted, tallest in cell 0.
// Depends on ssimh_pkg and ssimh_cell.
module ssimh_row import ssimh_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  cnt_t     cnt,
	output h_t       top0,
	output h_t       top1
);

	logic flag [MAX_BLD];
	h_t   key  [MAX_BLD];

	for (genvar i = 0; i < MAX_BLD; i++) begin : g_cell
		logic lflag;
		h_t   lkey;
		h_t   rkey;
		if (i == 0) begin : g_first
			assign lflag = 1'b0;
			assign lkey  = '0;
		end else begin : g_mid
			assign lflag = flag[i-1];
			assign lkey  = key[i-1];
		end
		if (i == MAX_BLD - 1) begin : g_last
			assign rkey = '0;
		end else begin : g_inner
			assign rkey = key[i+1];
		end
		ssimh_cell u_cell (
			.clk       (clk),
			.op        (op),
			.beyond    (cnt <= cnt_t'(i)),
			.left_flag (lflag),
			.left_key  (lkey),
			.right_key (rkey),
			.flag      (flag[i]),
			.key       (key[i])
		);
	end

	assign top0 = key[0];
	assign top1 = key[1];

endmodule

/* rtl/skyline_sweep_indexed_max_heap.sv */
`timescale 1ns / 1ps
// Skyline sweep top level: id table, event control, output register.
// Depends on ssimh_pkg, ssimh_if, ssimh_row.
//
//  channel | dir | handshake     | beat
//  evt     | in  | valid / ready | x_position, building_height, building_id, is_entering
//  key     | out | valid / ready | key_x, key_height
//
// Each event does an id table read, then at most one shift of the cell row.
// After reset the id table is swept clear while evt.ready is low.
// A key point waits in the output register; the next event is taken meanwhile,
// and its update cycle holds while that register is full and not being taken.
module skyline_sweep_indexed_max_heap import ssimh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ssimh_evt_if.sink    evt,
	ssimh_key_if.source  key
);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	idx_t       clr_q;
	cnt_t       cnt_q;
	evt_t       evt_q;
	logic [H_W:0] rd_q;
	key_t       out_q;
	logic       out_v_q;

	logic [H_W:0] tbl_mem [MAX_BLD];
	logic         tbl_we;
	idx_t         tbl_wa;
	logic [H_W:0] tbl_wd;

	logic     accept;
	logic     in_rng;
	logic     present;
	h_t       stored_h;
	logic     do_ins;
	logic     do_del;
	logic     go;
	logic     hit;
	h_t       cur_max;
	h_t       new_max;
	h_t       top0;
	h_t       top1;
	cell_op_t op;

	assign evt.ready = (state_q == ST_IDLE);
	assign accept    = evt.valid & evt.ready;

	assign in_rng   = int'(evt_q.building_id) < MAX_BLD;
	assign present  = rd_q[H_W];
	assign stored_h = rd_q[H_W-1:0];
	assign do_ins   = evt_q.is_entering & in_rng & ~present & (cnt_q < cnt_t'(MAX_BLD));
	assign do_del   = ~evt_q.is_entering & in_rng & present;

	assign cur_max = (cnt_q == '0) ? '0 : top0;
	assign new_max = (cnt_q == cnt_t'(1)) ? '0 : ((top0 <= stored_h) ? top1 : top0);
	assign hit     = do_ins ? (evt_q.building_height > cur_max)
	                        : (do_del & (evt_q.building_height > new_max));
	assign go      = (state_q == ST_EXEC) & (~out_v_q | key.ready);

	assign op.ins = go & do_ins;
	assign op.del = go & do_del;
	assign op.val = do_ins ? evt_q.building_height : stored_h;

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = clr_q;
		tbl_wd = '0;
		if (state_q == ST_CLR) begin
			tbl_we = 1'b1;
		end else if (go && (do_ins || do_del)) begin
			tbl_we = 1'b1;
			tbl_wa = idx_t'(evt_q.building_id);
			tbl_wd = do_ins ? {1'b1, evt_q.building_height} : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (accept) begin
			rd_q  <= tbl_mem[idx_t'(evt.beat.building_id)];
			evt_q <= evt.beat;
		end
		if (go && hit) begin
			out_q.key_x      <= evt_q.x_position;
			out_q.key_height <= do_ins ? evt_q.building_height : new_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(MAX_BLD - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (op.ins) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end else if (op.del) begin
				cnt_q <= cnt_q - cnt_t'(1);
			end
			if (go && hit) begin
				out_v_q <= 1'b1;
			end else if (key.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign key.valid = out_v_q;
	assign key.beat  = out_q;

	ssimh_row u_row (
		.clk  (clk),
		.op   (op),
		.cnt  (cnt_q),
		.top0 (top0),
		.top1 (top1)
	);

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(MAX_BLD))
		else $error("active count above capacity");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= cnt_t'(2) |-> top0 >= top1)
		else $error("cell row head out of order");

	a_key_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == ST_EXEC))
		else $error("key beat without an event update");

	a_no_evt_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !evt.ready && cnt_q == '0)
		else $error("event taken during table clear");
`endif

endmodule
